### src/blist_pkg.sv
// ----------------------------------------------------------------------------
// blist_pkg
// Shared widths, request codes and defaults for the bounded sequential list.
// ----------------------------------------------------------------------------
package blist_pkg;

  localparam int DATA_W       = 32;  // element width
  localparam int POS_W        = 7;   // position, found_at and count port width
  localparam int REQ_W        = 3;   // request code width
  localparam int CAPACITY_DEF = 64;  // default store depth

  typedef enum logic [REQ_W-1:0] {
    REQ_GET    = 3'd0,
    REQ_LOCATE = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_APPEND = 3'd3,
    REQ_DELETE = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

endpackage

### src/bounded_sequential_list.sv
// ----------------------------------------------------------------------------
// bounded_sequential_list
// Ordered list of signed 32-bit elements in a RAM of CAPACITY slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request transaction:
//   req_type (get, locate, insert, append, delete, clear), position, value.
//   Output channel (out_valid/out_ready) returns exactly one result
//   transaction per request: ok, read_value, found_at, count and flags.
//   One request is worked on at a time; in_ready is high only while the
//   sequencer is idle. All element traffic goes through the single RAM
//   read port and write port, one element per cycle.
//   Clear, append on a full list, failed range checks and unused codes go
//   straight to the result; append and insert at the tail write the value;
//   get reads one element; other inserts and delete shift the elements from
//   the position to the tail; locate scans up to count elements. Long
//   requests are bound by walking the store through the one RAM port pair.
//   A finished result sits in the output register; the next request is
//   accepted while it waits, and that request's result holds in the
//   sequencer until the receiver takes the earlier one.
//   Reset (rst_n low, synchronous) empties the list at once; the RAM is
//   not swept, since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module bounded_sequential_list
  import blist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic signed [POS_W-1:0]  out_found_at,
  output logic [POS_W-1:0]         out_count,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_DRAIN,
    S_WRVAL,
    S_FINISH
  } state_t;

  // sequencer registers
  state_t                   state_r,     state_nxt;
  req_t                     op_r,        op_nxt;
  logic [DATA_W-1:0]        key_r,       key_nxt;
  logic [ADDR_W-1:0]        tgt_r,       tgt_nxt;
  logic [CNT_W-1:0]         src_r,       src_nxt;
  logic [CNT_W-1:0]         count_r,     count_nxt;
  logic                     mv_vld_r,    mv_vld_nxt;
  logic [ADDR_W-1:0]        mv_dst_r,    mv_dst_nxt;
  logic                     cap_r,       cap_nxt;
  logic                     chk_vld_r,   chk_vld_nxt;
  logic [CNT_W-1:0]         chk_idx_r,   chk_idx_nxt;
  logic                     ok_r,        ok_nxt;
  logic [DATA_W-1:0]        rdval_r,     rdval_nxt;
  logic [POS_W-1:0]         found_r,     found_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_ok_r,    out_ok_nxt;
  logic [DATA_W-1:0]        out_rd_r,    out_rd_nxt;
  logic [POS_W-1:0]         out_found_r, out_found_nxt;
  logic [POS_W-1:0]         out_cnt_r,   out_cnt_nxt;
  logic                     out_emp_r,   out_emp_nxt;
  logic                     out_full_r,  out_full_nxt;

  // RAM port
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic                     not_full;

  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign not_full = (count_r != CNT_W'(CAPACITY));
  assign in_ready = (state_r == S_IDLE);

  blist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Write port: a pending element move has the port, else the new value.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mv_dst_r;
    ram_wdata = ram_rdata;
    if (mv_vld_r) begin
      ram_we = 1'b1;
    end else if (state_r == S_WRVAL) begin
      ram_we    = 1'b1;
      ram_waddr = tgt_r;
      ram_wdata = key_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    tgt_nxt       = tgt_r;
    src_nxt       = src_r;
    count_nxt     = count_r;
    mv_vld_nxt    = 1'b0;
    mv_dst_nxt    = mv_dst_r;
    cap_nxt       = 1'b0;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    ok_nxt        = ok_r;
    rdval_nxt     = rdval_r;
    found_nxt     = found_r;
    ram_raddr     = tgt_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_rd_nxt    = out_rd_r;
    out_found_nxt = out_found_r;
    out_cnt_nxt   = out_cnt_r;
    out_emp_nxt   = out_emp_r;
    out_full_nxt  = out_full_r;

    // capture the element read for get and delete
    if (cap_r) begin
      rdval_nxt = ram_rdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = req_t'(in_req_type);
          key_nxt   = in_value;
          ok_nxt    = 1'b0;
          rdval_nxt = '0;
          found_nxt = '1;
          state_nxt = S_FINISH;
          unique case (in_req_type)
            REQ_GET: begin
              if (pos_ext < cnt_ext) begin
                ok_nxt    = 1'b1;
                tgt_nxt   = ADDR_W'(pos_ext);
                state_nxt = S_READ;
              end else begin
                rdval_nxt = '1;
              end
            end
            REQ_LOCATE: begin
              ok_nxt  = 1'b1;
              src_nxt = '0;
              if (count_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            REQ_INSERT: begin
              if (pos_ext <= cnt_ext && not_full) begin
                ok_nxt  = 1'b1;
                tgt_nxt = ADDR_W'(pos_ext);
                src_nxt = count_r - CNT_W'(1);
                if (pos_ext == cnt_ext) begin
                  state_nxt = S_WRVAL;
                end else begin
                  state_nxt = S_SHUP;
                end
              end
            end
            REQ_APPEND: begin
              if (not_full) begin
                ok_nxt    = 1'b1;
                tgt_nxt   = ADDR_W'(count_r);
                state_nxt = S_WRVAL;
              end
            end
            REQ_DELETE: begin
              if (pos_ext < cnt_ext) begin
                ok_nxt    = 1'b1;
                tgt_nxt   = ADDR_W'(pos_ext);
                src_nxt   = CNT_W'(pos_ext) + CNT_W'(1);
                state_nxt = S_READ;
              end else begin
                rdval_nxt = '1;
              end
            end
            REQ_CLEAR: begin
              ok_nxt    = 1'b1;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        ram_raddr = tgt_r;
        cap_nxt   = 1'b1;
        if (op_r == REQ_GET) begin
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_SHDN;
        end
      end

      S_SCAN: begin
        ram_raddr = ADDR_W'(src_r);
        if (chk_vld_r && ram_rdata == key_r) begin
          found_nxt = POS_W'(chk_idx_r);
          state_nxt = S_FINISH;
        end else if (chk_vld_r && chk_idx_r == count_r - CNT_W'(1)) begin
          state_nxt = S_FINISH;
        end else if (src_r < count_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = src_r;
          src_nxt     = src_r + CNT_W'(1);
        end
      end

      // move the tail up one slot, highest element first
      S_SHUP: begin
        ram_raddr  = ADDR_W'(src_r);
        mv_vld_nxt = 1'b1;
        mv_dst_nxt = ADDR_W'(src_r + CNT_W'(1));
        if (src_r == CNT_W'(tgt_r)) begin
          state_nxt = S_DRAIN;
        end else begin
          src_nxt = src_r - CNT_W'(1);
        end
      end

      // move the tail down one slot, lowest element first
      S_SHDN: begin
        ram_raddr = ADDR_W'(src_r);
        if (src_r < count_r) begin
          mv_vld_nxt = 1'b1;
          mv_dst_nxt = ADDR_W'(src_r - CNT_W'(1));
          src_nxt    = src_r + CNT_W'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (op_r == REQ_INSERT) begin
          state_nxt = S_WRVAL;
        end else begin
          if (op_r == REQ_DELETE) begin
            count_nxt = count_r - CNT_W'(1);
          end
          state_nxt = S_FINISH;
        end
      end

      S_WRVAL: begin
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_rd_nxt    = rdval_r;
          out_found_nxt = found_r;
          out_cnt_nxt   = POS_W'(count_r);
          out_emp_nxt   = (count_r == '0);
          out_full_nxt  = !not_full;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mv_vld_r    <= 1'b0;
      cap_r       <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mv_vld_r    <= mv_vld_nxt;
      cap_r       <= cap_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    tgt_r       <= tgt_nxt;
    src_r       <= src_nxt;
    mv_dst_r    <= mv_dst_nxt;
    chk_idx_r   <= chk_idx_nxt;
    ok_r        <= ok_nxt;
    rdval_r     <= rdval_nxt;
    found_r     <= found_nxt;
    out_ok_r    <= out_ok_nxt;
    out_rd_r    <= out_rd_nxt;
    out_found_r <= out_found_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_emp_r   <= out_emp_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rd_r;
  assign out_found_at   = out_found_r;
  assign out_count      = out_cnt_r;
  assign out_is_empty   = out_emp_r;
  assign out_is_full    = out_full_r;

endmodule

### src/blist_ram.sv
// ----------------------------------------------------------------------------
// blist_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module blist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sim/bounded_sequential_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sequential_list_tb
// Self-checking bench for the bounded sequential list. A shadow copy of the
// list predicts every result transaction. Directed requests hit the edge
// cases first. Random request streams then grow the list to capacity, drain
// it, and mix all request kinds; both channels idle at random outside one back-to-back stretch.
// ----------------------------------------------------------------------------
module bounded_sequential_list_tb;
  import blist_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 800_000;
  localparam int IDLE_PCT     = 26;
  localparam int MAX_REPORTS  = 10;

  // Request codes the block must ignore
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic signed [POS_W-1:0]  found_at;
    logic [POS_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [REQ_W-1:0]         in_req_type = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_read_value;
  logic signed [POS_W-1:0]  out_found_at;
  logic [POS_W-1:0]         out_count;
  logic                     out_is_empty;
  logic                     out_is_full;

  // Shadow copy of the list, advanced once per accepted request
  logic signed [DATA_W-1:0] shadow_slots [CAPACITY];
  int                       shadow_count = 0;

  list_result_t expected_results [$];
  int           mismatch_count = 0;
  int           result_index = 0;
  int           cycle_count = 0;
  bit           back_to_back = 1'b0;  // suppress idling on both channels

  bounded_sequential_list #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_read_value(out_read_value),
    .out_found_at  (out_found_at),
    .out_count     (out_count),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Apply one request to the shadow list and return the result it must give
  function automatic list_result_t apply_list_request(input logic [REQ_W-1:0] kind,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic signed [DATA_W-1:0] val);
    list_result_t res;
    int n;
    int p;
    int i;
    res.ok         = 1'b0;
    res.read_value = '0;
    res.found_at   = '1;
    n = shadow_count;
    p = pos;
    case (kind)
      REQ_GET: begin
        if (p < n) begin
          res.read_value = shadow_slots[p];
          res.ok = 1'b1;
        end else begin
          res.read_value = '1;
        end
      end
      REQ_LOCATE: begin
        res.ok = 1'b1;
        // walk down so the lowest matching position wins
        for (i = n - 1; i >= 0; i--) begin
          if (shadow_slots[i] == val) res.found_at = POS_W'(i);
        end
      end
      REQ_INSERT: begin
        if (p <= n && n < CAPACITY) begin
          for (i = n; i > p; i--) shadow_slots[i] = shadow_slots[i - 1];
          shadow_slots[p] = val;
          shadow_count = n + 1;
          res.ok = 1'b1;
        end
      end
      REQ_APPEND: begin
        if (n < CAPACITY) begin
          shadow_slots[n] = val;
          shadow_count = n + 1;
          res.ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (p < n) begin
          res.read_value = shadow_slots[p];
          for (i = p; i + 1 < n; i++) shadow_slots[i] = shadow_slots[i + 1];
          shadow_slots[n - 1] = '0;
          shadow_count = n - 1;
          res.ok = 1'b1;
        end else begin
          res.read_value = '1;
        end
      end
      REQ_CLEAR: begin
        for (i = 0; i < CAPACITY; i++) shadow_slots[i] = '0;
        shadow_count = 0;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.count    = POS_W'(shadow_count);
    res.is_empty = (shadow_count == 0);
    res.is_full  = (shadow_count == CAPACITY);
    return res;
  endfunction

  // Drive one request transaction; called at a falling edge, returns at one
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    // idle the request channel at random
    if (!back_to_back) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_value    <= val;
    // hold until the block takes it
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(apply_list_request(kind, pos, val));
    @(negedge clk);
  endtask

  // Draw a random request. grow_pct biases list-changing requests toward
  // insert/append over delete; noise_pct sets the share of clears and
  // unused codes.
  task automatic pick_request(input int grow_pct, input int noise_pct,
                              output logic [REQ_W-1:0] kind, output logic [POS_W-1:0] pos,
                              output logic signed [DATA_W-1:0] val);
    int r;
    r = $urandom_range(99);
    if (r < noise_pct / 3) begin
      kind = REQ_CLEAR;
    end else if (r < noise_pct) begin
      kind = $urandom_range(1) ? REQ_SPARE_7 : REQ_SPARE_6;
    end else if (r < noise_pct + 38) begin
      kind = $urandom_range(1) ? REQ_LOCATE : REQ_GET;
    end else if ($urandom_range(99) < grow_pct) begin
      kind = $urandom_range(1) ? REQ_APPEND : REQ_INSERT;
    end else begin
      kind = REQ_DELETE;
    end

    // mostly in range, some from the count up to capacity, some anywhere in the field
    r = $urandom_range(99);
    if (r < 80)      pos = POS_W'($urandom_range(shadow_count));
    else if (r < 92) pos = POS_W'($urandom_range(CAPACITY, shadow_count));
    else             pos = POS_W'($urandom_range(127));

    // small values give duplicates and locate hits; keep extremes in play
    r = $urandom_range(99);
    if (kind == REQ_LOCATE && shadow_count > 0 && r < 60) begin
      val = shadow_slots[$urandom_range(shadow_count - 1)];
    end else if (r < 40) begin
      val = int'($urandom_range(15)) - 8;
    end else if (r < 50) begin
      case ($urandom_range(3))
        0:       val = 32'sh7FFF_FFFF;
        1:       val = 32'sh8000_0000;
        2:       val = -1;
        default: val = 0;
      endcase
    end else begin
      val = $urandom;
    end
  endtask

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= back_to_back || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transaction against the oldest prediction
  always @(posedge clk) begin : check_results
    list_result_t got;
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_ok, out_read_value, out_found_at, out_count, out_is_empty, out_is_full};
      result_index++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result %0d: no request outstanding (ok=%0b rd=%0d at=%0d cnt=%0d)",
                   result_index, got.ok, got.read_value, got.found_at, got.count);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $write("result %0d mismatch: expected ok=%0b rd=%0d at=%0d cnt=%0d e=%0b f=%0b,",
                   result_index, want.ok, want.read_value, want.found_at, want.count,
                   want.is_empty, want.is_full);
            $display(" got ok=%0b rd=%0d at=%0d cnt=%0d e=%0b f=%0b",
                     got.ok, got.read_value, got.found_at, got.count, got.is_empty,
                     got.is_full);
          end
        end
      end
    end
  end

  // Edge cases: empty list, field extremes, range checks, unused codes
  task automatic test_directed();
    send_request(REQ_GET,    7'd0,   32'sd5);          // get on empty list
    send_request(REQ_DELETE, 7'd0,   32'sd0);          // delete on empty list
    send_request(REQ_LOCATE, 7'd0,   32'sd0);          // locate on empty list
    send_request(REQ_INSERT, 7'd1,   32'sd9);          // insert past the tail
    send_request(REQ_APPEND, 7'd0,   32'sh7FFF_FFFF);
    send_request(REQ_APPEND, 7'd127, 32'sh8000_0000);
    send_request(REQ_INSERT, 7'd0,   -32'sd1);         // insert at head
    send_request(REQ_INSERT, 7'd3,   32'sd0);          // insert at tail
    send_request(REQ_INSERT, 7'd5,   32'sd1);          // position beyond count
    send_request(REQ_INSERT, 7'd127, 32'sd1);
    send_request(REQ_APPEND, 7'd0,   32'sh7FFF_FFFF);  // duplicate value
    send_request(REQ_GET,    7'd0,   32'sd0);
    send_request(REQ_GET,    7'd3,   32'sd0);
    send_request(REQ_GET,    7'd5,   32'sd0);          // position equal to count
    send_request(REQ_GET,    7'd127, 32'sd0);
    send_request(REQ_LOCATE, 7'd0,   32'sh8000_0000);
    send_request(REQ_LOCATE, 7'd0,   32'sh7FFF_FFFF);  // first of two copies
    send_request(REQ_LOCATE, 7'd64,  32'sd12345);      // absent key
    send_request(REQ_DELETE, 7'd1,   32'sd0);          // delete in the middle
    send_request(REQ_DELETE, 7'd4,   32'sd0);          // position equal to count
    send_request(REQ_DELETE, 7'd64,  32'sd0);
    send_request(REQ_SPARE_6, 7'd0,  32'sd0);
    send_request(REQ_SPARE_7, 7'd127, -32'sd1);
    send_request(REQ_CLEAR,  7'd3,   32'sd0);
    send_request(REQ_GET,    7'd0,   32'sd0);          // cleared list is empty
  endtask

  // Grow to capacity, push against the full list, then drain to empty
  task automatic test_fill_and_drain();
    logic [REQ_W-1:0]         kind;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       k;
    repeat (2) begin
      for (k = 0; k < 600 && shadow_count < CAPACITY; k++) begin
        pick_request(92, 0, kind, pos, val);
        send_request(kind, pos, val);
      end
      repeat (12) begin
        pick_request(90, 0, kind, pos, val);
        send_request(kind, pos, val);
      end
      for (k = 0; k < 600 && shadow_count > 0; k++) begin
        pick_request(8, 0, kind, pos, val);
        send_request(kind, pos, val);
      end
      repeat (12) begin
        pick_request(10, 0, kind, pos, val);
        send_request(kind, pos, val);
      end
    end
  endtask

  // Long stretch with both channels always ready
  task automatic test_back_to_back();
    logic [REQ_W-1:0]         kind;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    back_to_back = 1'b1;
    repeat (250) begin
      pick_request(60, 3, kind, pos, val);
      send_request(kind, pos, val);
    end
    back_to_back = 1'b0;
  endtask

  // Mixed traffic; rotate the growth bias so the count sweeps its range
  task automatic test_random_mix();
    logic [REQ_W-1:0]         kind;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       grow;
    int                       k;
    grow = 50;
    for (k = 0; k < 640; k++) begin
      if (k % 80 == 0) grow = $urandom_range(85, 20);
      pick_request(grow, 4, kind, pos, val);
      send_request(kind, pos, val);
    end
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) shadow_slots[i] = '0;
    // hold reset, release at a falling edge
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_drain();
    test_back_to_back();
    test_random_mix();
    in_valid <= 1'b0;

    // drain outstanding results, then allow one worst-case request time
    while (expected_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
